// ===== rtl/ncsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncsl_pkg: shared types and constants of the nesting-checked source lexer
// Token and error codes, lexer modes, and the beat passed from the front end
// to the back end.
// ----------------------------------------------------------------------------
package ncsl_pkg;

  localparam int unsigned ColumnBitsDef   = 12;
  localparam int unsigned LineBitsDef     = 16;
  localparam int unsigned DepthBitsDef    = 16;
  localparam int unsigned KeywordCharsDef = 5;

  // input kinds
  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_EOL     = 2'd1;
  localparam logic [1:0] KIND_EOI     = 2'd2;
  localparam logic [1:0] KIND_RESTART = 2'd3;

  // result kinds
  localparam logic [1:0] RK_TOKEN = 2'd0;
  localparam logic [1:0] RK_ERROR = 2'd1;
  localparam logic [1:0] RK_DONE  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_PAREN   = 3'd0;
  localparam logic [2:0] ERR_BRACKET = 3'd1;
  localparam logic [2:0] ERR_BRACE   = 3'd2;
  localparam logic [2:0] ERR_STRING  = 3'd3;
  localparam logic [2:0] ERR_NUMBER  = 3'd4;
  localparam logic [2:0] ERR_CHAR    = 3'd5;

  // token codes
  localparam logic [5:0] T_LPAREN = 6'd0;
  localparam logic [5:0] T_RPAREN = 6'd1;
  localparam logic [5:0] T_LBRACK = 6'd2;
  localparam logic [5:0] T_RBRACK = 6'd3;
  localparam logic [5:0] T_LBRACE = 6'd4;
  localparam logic [5:0] T_RBRACE = 6'd5;
  localparam logic [5:0] T_LT     = 6'd6;
  localparam logic [5:0] T_LE     = 6'd7;
  localparam logic [5:0] T_SHL    = 6'd8;
  localparam logic [5:0] T_LARROW = 6'd9;
  localparam logic [5:0] T_GT     = 6'd10;
  localparam logic [5:0] T_GE     = 6'd11;
  localparam logic [5:0] T_SHR    = 6'd12;
  localparam logic [5:0] T_ASSIGN = 6'd13;
  localparam logic [5:0] T_SCOPE  = 6'd14;
  localparam logic [5:0] T_PLUS   = 6'd15;
  localparam logic [5:0] T_SUB    = 6'd16;
  localparam logic [5:0] T_MUL    = 6'd17;
  localparam logic [5:0] T_POW    = 6'd18;
  localparam logic [5:0] T_DIV    = 6'd19;
  localparam logic [5:0] T_MOD    = 6'd20;
  localparam logic [5:0] T_AND    = 6'd21;
  localparam logic [5:0] T_LAND   = 6'd22;
  localparam logic [5:0] T_OR     = 6'd23;
  localparam logic [5:0] T_LOR    = 6'd24;
  localparam logic [5:0] T_NOT    = 6'd25;
  localparam logic [5:0] T_TILDE  = 6'd26;
  localparam logic [5:0] T_XOR    = 6'd27;
  localparam logic [5:0] T_IDENT  = 6'd28;
  localparam logic [5:0] T_INT    = 6'd29;
  localparam logic [5:0] T_FLOAT  = 6'd30;
  localparam logic [5:0] T_STR    = 6'd31;
  localparam logic [5:0] T_KW0    = 6'd32;
  localparam int unsigned NumKw   = 19;

  // lexer modes
  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_OP   = 3'd1;
  localparam logic [2:0] M_WORD = 3'd2;
  localparam logic [2:0] M_NUM  = 3'd3;
  localparam logic [2:0] M_STR  = 3'd4;
  localparam logic [2:0] M_SKIP = 3'd5;

  // character classes from the front end
  typedef enum logic [3:0] {
    CC_SPACE, CC_DIGIT, CC_ALPHA, CC_DOT, CC_QUOTE, CC_BSLASH,
    CC_OPEN, CC_CLOSE, CC_OPCHAR, CC_SINGLE, CC_OTHER
  } char_class_e;

  // classified beat in the queue
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    char_class_e cls;
    logic [1:0]  nest;    // 0 paren, 1 bracket, 2 brace
    logic [5:0]  single;  // token of a single-character symbol / opener / closer
  } beat_t;

  // keyword text, packed right-aligned 8 bits a letter, with length
  function automatic logic [63:0] kw_text(input int unsigned k);
    logic [63:0] v;
    v = '0;
    case (k)
      0:  v = 64'h666e;
      1:  v = 64'h6c6f6f70;
      2:  v = 64'h6966;
      3:  v = 64'h6c656e;
      4:  v = 64'h6174;
      5:  v = 64'h76696577;
      6:  v = 64'h71756f7465;
      7:  v = 64'h6576616c;
      8:  v = 64'h64726f70;
      9:  v = 64'h74797065;
      10: v = 64'h71756974;
      11: v = 64'h726576;
      12: v = 64'h737562;
      13: v = 64'h6177616974;
      14: v = 64'h757365;
      15: v = 64'h6c6f6164;
      16: v = 64'h706172616d;
      17: v = 64'h6d6f64;
      18: v = 64'h707562;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] kw_len(input int unsigned k);
    logic [3:0] l;
    l = 4'd0;
    case (k)
      0, 2, 4: l = 4'd2;
      3, 11, 12, 14, 17, 18: l = 4'd3;
      1, 5, 7, 8, 9, 10, 15: l = 4'd4;
      6, 13, 16: l = 4'd5;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

endpackage

// ===== rtl/nesting_checked_source_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nesting_checked_source_lexer: streaming lexer with nesting checks
// One source character, end of line, end of input or restart per input beat;
// tokens, errors and a completion report out as result beats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries kind_i and char_code_i.
//   Output channel (out_valid_o / out_ready_i) carries one result per beat;
//   last_o marks the final result caused by one input beat. A beat causes
//   zero, one or two results.
//   A result passes the input register, a queue entry and the lexer
//   step registered into the result buffer before it appears.
//   Throughput: one input beat per cycle while each causes at most one
//   result and the receiver is ready; a beat with two results holds
//   the lexer until the result buffer, draining one a cycle, has room.
//   Reset clears all counters, depths and the lexer mode at once; a restart
//   beat does the same in band. When the receiver stalls, the result buffer
//   holds, the lexer stops, and the two-entry queue and input register
//   fill before in_ready_o drops.
// ----------------------------------------------------------------------------
module nesting_checked_source_lexer #(
  parameter int unsigned COLUMN_BITS   = ncsl_pkg::ColumnBitsDef,
  parameter int unsigned LINE_BITS     = ncsl_pkg::LineBitsDef,
  parameter int unsigned DEPTH_BITS    = ncsl_pkg::DepthBitsDef,
  parameter int unsigned KEYWORD_CHARS = ncsl_pkg::KeywordCharsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [5:0]  token_code_o,
  output logic [2:0]  error_code_o,
  output logic [1:0]  unclosed_o,
  output logic [15:0] line_number_o,
  output logic [11:0] start_column_o,
  output logic [12:0] token_length_o,
  output logic        last_o
);

  logic            f_valid, f_ready, b_valid, b_ready;
  ncsl_pkg::beat_t f_beat, b_beat;

  // classify each beat
  ncsl_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .kind_i, .char_code_i,
    .q_valid_o(f_valid), .q_ready_i(f_ready), .q_beat_o(f_beat)
  );

  // decouple classification from lexing
  ncsl_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_beat_i(f_beat),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_beat_o(b_beat)
  );

  // advance lexer state and issue results
  ncsl_back #(
    .COLUMN_BITS(COLUMN_BITS), .LINE_BITS(LINE_BITS),
    .DEPTH_BITS(DEPTH_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(b_valid), .q_ready_o(b_ready), .q_beat_i(b_beat),
    .out_valid_o, .out_ready_i, .result_kind_o, .token_code_o, .error_code_o,
    .unclosed_o, .line_number_o, .start_column_o, .token_length_o, .last_o
  );

endmodule

// ===== rtl/ncsl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncsl_front: input stage and character classifier
// Registers each accepted beat with its character class and symbol token.
// ----------------------------------------------------------------------------
module ncsl_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     kind_i,
  input  logic [7:0]     char_code_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output ncsl_pkg::beat_t q_beat_o
);

  logic            valid_q;
  ncsl_pkg::beat_t beat_q, beat_d;

  assign in_ready_o = !valid_q || q_ready_i;
  assign q_valid_o  = valid_q;
  assign q_beat_o   = beat_q;

  always_comb begin
    beat_d        = '0;
    beat_d.kind   = kind_i;
    beat_d.ch     = char_code_i;
    beat_d.cls    = ncsl_pkg::CC_OTHER;
    beat_d.nest   = 2'd0;
    beat_d.single = '0;
    if (char_code_i >= 8'h30 && char_code_i <= 8'h39) begin
      beat_d.cls = ncsl_pkg::CC_DIGIT;
    end else if ((char_code_i >= 8'h61 && char_code_i <= 8'h7a) ||
                 (char_code_i >= 8'h41 && char_code_i <= 8'h5a)) begin
      beat_d.cls = ncsl_pkg::CC_ALPHA;
    end else begin
      case (char_code_i)
        8'h20: beat_d.cls = ncsl_pkg::CC_SPACE;
        8'h2e: beat_d.cls = ncsl_pkg::CC_DOT;
        8'h22: beat_d.cls = ncsl_pkg::CC_QUOTE;
        8'h5c: beat_d.cls = ncsl_pkg::CC_BSLASH;
        8'h28: begin
          beat_d.cls = ncsl_pkg::CC_OPEN; beat_d.nest = 2'd0;
          beat_d.single = ncsl_pkg::T_LPAREN;
        end
        8'h29: begin
          beat_d.cls = ncsl_pkg::CC_CLOSE; beat_d.nest = 2'd0;
          beat_d.single = ncsl_pkg::T_RPAREN;
        end
        8'h5b: begin
          beat_d.cls = ncsl_pkg::CC_OPEN; beat_d.nest = 2'd1;
          beat_d.single = ncsl_pkg::T_LBRACK;
        end
        8'h5d: begin
          beat_d.cls = ncsl_pkg::CC_CLOSE; beat_d.nest = 2'd1;
          beat_d.single = ncsl_pkg::T_RBRACK;
        end
        8'h7b: begin
          beat_d.cls = ncsl_pkg::CC_OPEN; beat_d.nest = 2'd2;
          beat_d.single = ncsl_pkg::T_LBRACE;
        end
        8'h7d: begin
          beat_d.cls = ncsl_pkg::CC_CLOSE; beat_d.nest = 2'd2;
          beat_d.single = ncsl_pkg::T_RBRACE;
        end
        8'h3c, 8'h3e, 8'h3a, 8'h2a, 8'h26, 8'h7c, 8'h2d:
          beat_d.cls = ncsl_pkg::CC_OPCHAR;
        8'h2b: begin beat_d.cls = ncsl_pkg::CC_SINGLE; beat_d.single = ncsl_pkg::T_PLUS; end
        8'h2f: begin beat_d.cls = ncsl_pkg::CC_SINGLE; beat_d.single = ncsl_pkg::T_DIV; end
        8'h25: begin beat_d.cls = ncsl_pkg::CC_SINGLE; beat_d.single = ncsl_pkg::T_MOD; end
        8'h21: begin beat_d.cls = ncsl_pkg::CC_SINGLE; beat_d.single = ncsl_pkg::T_NOT; end
        8'h7e: begin beat_d.cls = ncsl_pkg::CC_SINGLE; beat_d.single = ncsl_pkg::T_TILDE; end
        8'h5e: begin beat_d.cls = ncsl_pkg::CC_SINGLE; beat_d.single = ncsl_pkg::T_XOR; end
        default: beat_d.cls = ncsl_pkg::CC_OTHER;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      beat_q <= beat_d;
    end
  end

endmodule

// ===== rtl/ncsl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncsl_queue: two-entry queue between front and back end
// Lets either side stall without stopping the other until the queue fills or empties.
// ----------------------------------------------------------------------------
module ncsl_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  ncsl_pkg::beat_t wr_beat_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output ncsl_pkg::beat_t rd_beat_o
);

  ncsl_pkg::beat_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_beat_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_beat_i;
  end

endmodule

// ===== rtl/ncsl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncsl_back: lexer state machine and result issue
// Steps the lexer state one beat a cycle while the result buffer has room,
// holds up to two results, then hands them out one by one.
// ----------------------------------------------------------------------------
module ncsl_back #(
  parameter int unsigned COLUMN_BITS   = ncsl_pkg::ColumnBitsDef,
  parameter int unsigned LINE_BITS     = ncsl_pkg::LineBitsDef,
  parameter int unsigned DEPTH_BITS    = ncsl_pkg::DepthBitsDef,
  parameter int unsigned KEYWORD_CHARS = ncsl_pkg::KeywordCharsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  ncsl_pkg::beat_t q_beat_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      result_kind_o,
  output logic [5:0]      token_code_o,
  output logic [2:0]      error_code_o,
  output logic [1:0]      unclosed_o,
  output logic [15:0]     line_number_o,
  output logic [11:0]     start_column_o,
  output logic [12:0]     token_length_o,
  output logic            last_o
);

  localparam int unsigned LenBits = COLUMN_BITS + 1;
  localparam int unsigned PreBits = 8 * KEYWORD_CHARS;
  localparam logic [DEPTH_BITS-1:0]  DepthMax = '1;
  localparam logic [LINE_BITS-1:0]   LineMax  = '1;
  localparam logic [COLUMN_BITS-1:0] ColMax   = '1;
  localparam logic [LenBits-1:0]     LenMax   = LenBits'(1) << COLUMN_BITS;

  typedef struct packed {
    logic [1:0]             rk;
    logic [5:0]             tok;
    logic [2:0]             err;
    logic [1:0]             unc;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [LenBits-1:0]     len;
  } res_t;

  // lexer state
  logic [DEPTH_BITS-1:0]  dep_q [3];
  logic [DEPTH_BITS-1:0]  dep_d [3];
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d, tstart_q, tstart_d;
  logic [2:0]             mode_q, mode_d;
  logic [7:0]             pend_q, pend_d;
  logic [LenBits-1:0]     tcnt_q, tcnt_d;
  logic [PreBits-1:0]     pre_q, pre_d;
  logic [2:0]             nfl_q, nfl_d;
  logic [1:0]             sfl_q, sfl_d;

  // result buffer: up to two results
  res_t       r0_q, r1_q, r0_d, r1_d;
  logic [1:0] rcnt_q, rcnt_d;
  logic       ridx_q;

  logic step;
  assign q_ready_o = (rcnt_q == 2'd0) || (rcnt_q == 2'd1 && ridx_q == 1'b1 && out_ready_i)
                     || (rcnt_q == 2'd1 && ridx_q == 1'b0 && out_ready_i);
  assign step = q_valid_i && q_ready_o;

  res_t cur;
  assign cur = ridx_q ? r1_q : r0_q;
  assign out_valid_o    = (rcnt_q != 2'd0);
  assign result_kind_o  = cur.rk;
  assign token_code_o   = cur.tok;
  assign error_code_o   = cur.err;
  assign unclosed_o     = cur.unc;
  assign line_number_o  = 16'(cur.line);
  assign start_column_o = 12'(cur.col);
  assign token_length_o = 13'(cur.len);
  assign last_o         = (rcnt_q == 2'd1);

  // keyword match over the held prefix
  function automatic logic [5:0] word_code(input logic [PreBits-1:0] p,
                                           input logic [LenBits-1:0] n);
    logic [5:0] r;
    r = ncsl_pkg::T_IDENT;
    if (n <= LenBits'(KEYWORD_CHARS)) begin
      for (int unsigned k = 0; k < ncsl_pkg::NumKw; k++) begin
        if (LenBits'(ncsl_pkg::kw_len(k)) == n &&
            PreBits'(ncsl_pkg::kw_text(k)) == p) begin
          r = ncsl_pkg::T_KW0 + 6'(k);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] op_pair(input logic [7:0] p, input logic [7:0] c);
    logic [6:0] r;  // bit 6 set: no pair
    r = 7'h40;
    case (p)
      8'h3c: r = c == 8'h3d ? {1'b0, ncsl_pkg::T_LE} : c == 8'h3c ? {1'b0, ncsl_pkg::T_SHL}
                 : c == 8'h2d ? {1'b0, ncsl_pkg::T_LARROW} : 7'h40;
      8'h3e: r = c == 8'h3d ? {1'b0, ncsl_pkg::T_GE} : c == 8'h3e ? {1'b0, ncsl_pkg::T_SHR}
                 : 7'h40;
      8'h3a: r = c == 8'h3d ? {1'b0, ncsl_pkg::T_ASSIGN} : c == 8'h3a ? {1'b0, ncsl_pkg::T_SCOPE}
                 : 7'h40;
      8'h2a: r = c == 8'h2a ? {1'b0, ncsl_pkg::T_POW} : 7'h40;
      8'h26: r = c == 8'h26 ? {1'b0, ncsl_pkg::T_LAND} : 7'h40;
      8'h7c: r = c == 8'h7c ? {1'b0, ncsl_pkg::T_LOR} : 7'h40;
      default: r = 7'h40;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] op_single(input logic [7:0] p);
    logic [6:0] r;
    r = 7'h40;
    case (p)
      8'h3c: r = {1'b0, ncsl_pkg::T_LT};
      8'h3e: r = {1'b0, ncsl_pkg::T_GT};
      8'h2a: r = {1'b0, ncsl_pkg::T_MUL};
      8'h26: r = {1'b0, ncsl_pkg::T_AND};
      8'h7c: r = {1'b0, ncsl_pkg::T_OR};
      8'h2d: r = {1'b0, ncsl_pkg::T_SUB};
      default: r = 7'h40;
    endcase
    return r;
  endfunction

  always_comb begin
    logic [LINE_BITS-1:0] cl;
    logic [6:0]           pc;
    logic                 used;
    logic [1:0]           n;
    res_t                 rs [2];
    ncsl_pkg::char_class_e cls;
    logic [7:0]           c;
    logic [1:0]           ni;

    for (int i = 0; i < 3; i++) dep_d[i] = dep_q[i];
    line_d = line_q; col_d = col_q; tstart_d = tstart_q; mode_d = mode_q;
    pend_d = pend_q; tcnt_d = tcnt_q; pre_d = pre_q; nfl_d = nfl_q; sfl_d = sfl_q;
    cl   = (line_q == LineMax) ? LineMax : line_q + 1'b1;
    n    = 2'd0;
    used = 1'b0;
    rs[0] = '0; rs[1] = '0;
    c   = q_beat_i.ch;
    cls = q_beat_i.cls;
    ni  = q_beat_i.nest;
    pc  = '0;

    if (step) begin
      case (q_beat_i.kind)
        ncsl_pkg::KIND_CHAR: begin
          // settle whatever is pending
          case (mode_q)
            ncsl_pkg::M_SKIP: used = 1'b1;
            ncsl_pkg::M_STR: begin
              used = 1'b1;
              if (tcnt_q < LenMax) tcnt_d = tcnt_q + 1'b1;
              if (cls == ncsl_pkg::CC_QUOTE && !sfl_q[0]) begin
                rs[0] = '{ncsl_pkg::RK_TOKEN, ncsl_pkg::T_STR, 3'd0, 2'd0, cl, tstart_q, tcnt_d};
                n = 2'd1;
                mode_d = ncsl_pkg::M_IDLE;
              end else begin
                sfl_d = {cls == ncsl_pkg::CC_QUOTE, cls == ncsl_pkg::CC_BSLASH};
              end
            end
            ncsl_pkg::M_OP: begin
              pc = op_pair(pend_q, c);
              if (!pc[6]) begin
                rs[0] = '{ncsl_pkg::RK_TOKEN, pc[5:0], 3'd0, 2'd0, cl, tstart_q, LenBits'(2)};
                n = 2'd1;
                mode_d = ncsl_pkg::M_IDLE;
                used = 1'b1;
              end else if (pend_q == 8'h2d && cls == ncsl_pkg::CC_DIGIT) begin
                mode_d = ncsl_pkg::M_NUM;
                tcnt_d = LenBits'(2);
                nfl_d  = 3'd0;
                used   = 1'b1;
              end else begin
                pc = op_single(pend_q);
                if (!pc[6]) begin
                  rs[0] = '{ncsl_pkg::RK_TOKEN, pc[5:0], 3'd0, 2'd0, cl, tstart_q, LenBits'(1)};
                  n = 2'd1;
                end
                mode_d = ncsl_pkg::M_IDLE;
              end
            end
            ncsl_pkg::M_WORD: begin
              if (cls == ncsl_pkg::CC_ALPHA || cls == ncsl_pkg::CC_DIGIT) begin
                if (tcnt_q < LenBits'(KEYWORD_CHARS)) pre_d = {pre_q[PreBits-9:0], c};
                if (tcnt_q < LenMax) tcnt_d = tcnt_q + 1'b1;
                used = 1'b1;
              end else begin
                rs[0] = '{ncsl_pkg::RK_TOKEN, word_code(pre_q, tcnt_q), 3'd0, 2'd0, cl,
                          tstart_q, tcnt_q};
                n = 2'd1;
                mode_d = ncsl_pkg::M_IDLE;
              end
            end
            ncsl_pkg::M_NUM: begin
              if (cls == ncsl_pkg::CC_DIGIT) begin
                nfl_d = {1'b0, nfl_q[1:0]};
                if (tcnt_q < LenMax) tcnt_d = tcnt_q + 1'b1;
                used = 1'b1;
              end else if (cls == ncsl_pkg::CC_DOT) begin
                nfl_d = {1'b1, nfl_q[1] | nfl_q[0], 1'b1};
                if (tcnt_q < LenMax) tcnt_d = tcnt_q + 1'b1;
                used = 1'b1;
              end else if (nfl_q[2] || nfl_q[1]) begin
                rs[0] = '{ncsl_pkg::RK_ERROR, 6'd0, ncsl_pkg::ERR_NUMBER, 2'd0, cl,
                          tstart_q, '0};
                n = 2'd1;
                mode_d = ncsl_pkg::M_SKIP;
                used = 1'b1;
              end else begin
                rs[0] = '{ncsl_pkg::RK_TOKEN, nfl_q[0] ? ncsl_pkg::T_FLOAT : ncsl_pkg::T_INT,
                          3'd0, 2'd0, cl, tstart_q, tcnt_q};
                n = 2'd1;
                mode_d = ncsl_pkg::M_IDLE;
              end
            end
            default: mode_d = ncsl_pkg::M_IDLE;
          endcase

          // start a new item with this character
          if (!used) begin
            case (cls)
              ncsl_pkg::CC_SPACE: ;
              ncsl_pkg::CC_OPEN: begin
                if (dep_q[ni] != DepthMax) dep_d[ni] = dep_q[ni] + 1'b1;
                rs[n[0]] = '{ncsl_pkg::RK_TOKEN, q_beat_i.single, 3'd0, 2'd0, cl, col_q,
                             LenBits'(1)};
                n = n + 2'd1;
              end
              ncsl_pkg::CC_CLOSE: begin
                if (dep_q[ni] == '0) begin
                  rs[n[0]] = '{ncsl_pkg::RK_ERROR, 6'd0, {1'b0, ni}, 2'd0, cl, col_q, '0};
                  mode_d = ncsl_pkg::M_SKIP;
                end else begin
                  dep_d[ni] = dep_q[ni] - 1'b1;
                  rs[n[0]] = '{ncsl_pkg::RK_TOKEN, q_beat_i.single, 3'd0, 2'd0, cl, col_q,
                               LenBits'(1)};
                end
                n = n + 2'd1;
              end
              ncsl_pkg::CC_OPCHAR: begin
                mode_d = ncsl_pkg::M_OP; pend_d = c; tstart_d = col_q;
              end
              ncsl_pkg::CC_SINGLE: begin
                rs[n[0]] = '{ncsl_pkg::RK_TOKEN, q_beat_i.single, 3'd0, 2'd0, cl, col_q,
                             LenBits'(1)};
                n = n + 2'd1;
              end
              ncsl_pkg::CC_QUOTE: begin
                mode_d = ncsl_pkg::M_STR; tstart_d = col_q; tcnt_d = LenBits'(1);
                sfl_d = 2'b10;
              end
              ncsl_pkg::CC_DIGIT: begin
                mode_d = ncsl_pkg::M_NUM; tstart_d = col_q; tcnt_d = LenBits'(1);
                nfl_d = 3'd0;
              end
              ncsl_pkg::CC_ALPHA: begin
                mode_d = ncsl_pkg::M_WORD; tstart_d = col_q; tcnt_d = LenBits'(1);
                pre_d = PreBits'(c);
              end
              default: begin
                tstart_d = col_q; tcnt_d = LenBits'(1);
                rs[n[0]] = '{ncsl_pkg::RK_ERROR, 6'd0, ncsl_pkg::ERR_CHAR, 2'd0, cl, col_q, '0};
                n = n + 2'd1;
                mode_d = ncsl_pkg::M_SKIP;
              end
            endcase
          end
          if (col_q != ColMax) col_d = col_q + 1'b1;
        end

        ncsl_pkg::KIND_EOL, ncsl_pkg::KIND_EOI: begin
          case (mode_q)
            ncsl_pkg::M_OP: begin
              pc = op_single(pend_q);
              if (!pc[6]) begin
                rs[0] = '{ncsl_pkg::RK_TOKEN, pc[5:0], 3'd0, 2'd0, cl, tstart_q, LenBits'(1)};
                n = 2'd1;
              end
            end
            ncsl_pkg::M_WORD: begin
              rs[0] = '{ncsl_pkg::RK_TOKEN, word_code(pre_q, tcnt_q), 3'd0, 2'd0, cl,
                        tstart_q, tcnt_q};
              n = 2'd1;
            end
            ncsl_pkg::M_NUM: begin
              if (nfl_q[2] || nfl_q[1])
                rs[0] = '{ncsl_pkg::RK_ERROR, 6'd0, ncsl_pkg::ERR_NUMBER, 2'd0, cl,
                          tstart_q, '0};
              else
                rs[0] = '{ncsl_pkg::RK_TOKEN, nfl_q[0] ? ncsl_pkg::T_FLOAT : ncsl_pkg::T_INT,
                          3'd0, 2'd0, cl, tstart_q, tcnt_q};
              n = 2'd1;
            end
            ncsl_pkg::M_STR: begin
              if (sfl_q[1])
                rs[0] = '{ncsl_pkg::RK_TOKEN, ncsl_pkg::T_STR, 3'd0, 2'd0, cl, tstart_q, tcnt_q};
              else
                rs[0] = '{ncsl_pkg::RK_ERROR, 6'd0, ncsl_pkg::ERR_STRING, 2'd0, cl,
                          tstart_q, '0};
              n = 2'd1;
            end
            default: ;
          endcase
          mode_d = ncsl_pkg::M_IDLE;
          if (line_q != LineMax) line_d = line_q + 1'b1;
          col_d = '0;
          if (q_beat_i.kind == ncsl_pkg::KIND_EOI) begin
            rs[n[0]] = '{ncsl_pkg::RK_DONE, 6'd0, 3'd0,
                         (dep_q[0] != '0) ? 2'd1 : (dep_q[1] != '0) ? 2'd2 :
                         (dep_q[2] != '0) ? 2'd3 : 2'd0, '0, '0, '0};
            n = n + 2'd1;
          end
        end

        default: begin
          for (int i = 0; i < 3; i++) dep_d[i] = '0;
          line_d = '0; col_d = '0; tstart_d = '0; mode_d = ncsl_pkg::M_IDLE;
          pend_d = '0; tcnt_d = '0; pre_d = '0; nfl_d = '0; sfl_d = '0;
        end
      endcase
    end

    r0_d = rs[0];
    r1_d = rs[1];
    rcnt_d = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) dep_q[i] <= '0;
      line_q <= '0; col_q <= '0; tstart_q <= '0; mode_q <= ncsl_pkg::M_IDLE;
      pend_q <= '0; tcnt_q <= '0; pre_q <= '0; nfl_q <= '0; sfl_q <= '0;
      rcnt_q <= 2'd0; ridx_q <= 1'b0;
    end else begin
      for (int i = 0; i < 3; i++) dep_q[i] <= dep_d[i];
      line_q <= line_d; col_q <= col_d; tstart_q <= tstart_d; mode_q <= mode_d;
      pend_q <= pend_d; tcnt_q <= tcnt_d; pre_q <= pre_d; nfl_q <= nfl_d; sfl_q <= sfl_d;
      if (step) begin
        rcnt_q <= rcnt_d;
        ridx_q <= 1'b0;
      end else if (out_valid_o && out_ready_i) begin
        rcnt_q <= rcnt_q - 2'd1;
        ridx_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      r0_q <= r0_d;
      r1_q <= r1_d;
    end
  end

endmodule
